/* rtl/timer_event_list_scheduler_core_assert.svh */
// ----------------------------------------------------------------------------
// Timer list scheduler assertion macros
// Concurrent check macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef TIMER_EVENT_LIST_SCHEDULER_CORE_ASSERT_SVH
`define TIMER_EVENT_LIST_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TEL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define TEL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/tel_pkg.sv */
// ----------------------------------------------------------------------------
// Timer list scheduler package
// Shared constants, opcodes, state and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package tel_pkg;

   localparam int SLOTS_DEF       = 16;
   localparam int TIME_BITS_DEF   = 32;
   localparam int OP_BITS         = 2;
   localparam int SLOT_BITS       = 4;
   localparam int TIME_FIELD_BITS = 32;

   // request opcodes; code 3 is unused
   localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_FINISH
   } state_type;

   // chain-wide control from the sequencer
   typedef struct packed {
      logic shift_left;   // rotate one entry out of the head
      logic keep_head;    // head entry goes back in at the tail
      logic shift_right;  // push a new entry in at the head
   } chain_ctrl_type;

   // control seen by one cell
   typedef struct packed {
      logic take_head;
      logic shift_left;
      logic shift_right;
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* rtl/tel_if.sv */
// ----------------------------------------------------------------------------
// Timer list scheduler channels
// Valid/ready request and response channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface tel_req_if
   import tel_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [OP_BITS-1:0]         op;
   logic [SLOT_BITS-1:0]       slot_id;
   logic [TIME_FIELD_BITS-1:0] delay_ticks;
   logic [TIME_FIELD_BITS-1:0] now_ticks;

   modport source (output valid, op, slot_id, delay_ticks, now_ticks, input ready);
   modport sink   (input valid, op, slot_id, delay_ticks, now_ticks, output ready);
endinterface

interface tel_rsp_if
   import tel_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic                       fired;
   logic [SLOT_BITS-1:0]       fired_slot;
   logic [TIME_FIELD_BITS-1:0] fire_time;
   logic                       last_result;

   modport source (output valid, fired, fired_slot, fire_time, last_result, input ready);
   modport sink   (input valid, fired, fired_slot, fire_time, last_result, output ready);
endinterface

`default_nettype wire

/* rtl/tel_cell.sv */
// ----------------------------------------------------------------------------
// Timer list cell
// One list position: slot number and trigger time, moved left or right.
// ----------------------------------------------------------------------------
`default_nettype none

module tel_cell
   import tel_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [SLOT_BITS-1:0] head_slot,
   input  wire logic [TIME_BITS-1:0] head_trig,
   input  wire logic [SLOT_BITS-1:0] right_slot,
   input  wire logic [TIME_BITS-1:0] right_trig,
   input  wire logic [SLOT_BITS-1:0] left_slot,
   input  wire logic [TIME_BITS-1:0] left_trig,
   output logic      [SLOT_BITS-1:0] slot_q,
   output logic      [TIME_BITS-1:0] trig_q
);

   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [TIME_BITS-1:0] trig_ff, trig_in;

   always_comb begin
      priority if (ctrl.take_head) begin
         slot_in = head_slot;
         trig_in = head_trig;
      end else if (ctrl.shift_left) begin
         slot_in = right_slot;
         trig_in = right_trig;
      end else if (ctrl.shift_right) begin
         slot_in = left_slot;
         trig_in = left_trig;
      end else begin
         slot_in = slot_ff;
         trig_in = trig_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      trig_ff <= trig_in;
   end

   assign slot_q = slot_ff;
   assign trig_q = trig_ff;

endmodule

`default_nettype wire

/* rtl/tel_chain.sv */
// ----------------------------------------------------------------------------
// Timer list cell chain
// Row of cells holding the armed list in order, front at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tel_chain
   import tel_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF,
   localparam int CNT_BITS = $clog2(SLOTS + 1)
) (
   input  wire logic                 clock,
   input  wire chain_ctrl_type       ctrl,
   input  wire logic [CNT_BITS-1:0]  count,
   input  wire logic [SLOT_BITS-1:0] ins_slot,
   input  wire logic [TIME_BITS-1:0] ins_trig,
   output logic      [SLOT_BITS-1:0] head_slot,
   output logic      [TIME_BITS-1:0] head_trig
);

   logic [SLOT_BITS-1:0] slot_q [SLOTS];
   logic [TIME_BITS-1:0] trig_q [SLOTS];
   logic [CNT_BITS-1:0]  tail_idx;

   // kept head goes to the last occupied position after the shift
   assign tail_idx = count - CNT_BITS'(1);

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      cell_ctrl_type        cc;
      logic [SLOT_BITS-1:0] r_slot, l_slot;
      logic [TIME_BITS-1:0] r_trig, l_trig;

      assign cc.take_head   = ctrl.keep_head && (tail_idx == CNT_BITS'(i));
      assign cc.shift_left  = ctrl.shift_left;
      assign cc.shift_right = ctrl.shift_right;

      if (i == SLOTS - 1) begin : g_last
         assign r_slot = slot_q[0];
         assign r_trig = trig_q[0];
      end else begin : g_mid
         assign r_slot = slot_q[i+1];
         assign r_trig = trig_q[i+1];
      end

      if (i == 0) begin : g_first
         assign l_slot = ins_slot;
         assign l_trig = ins_trig;
      end else begin : g_rest
         assign l_slot = slot_q[i-1];
         assign l_trig = trig_q[i-1];
      end

      tel_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cc),
         .head_slot  (slot_q[0]),
         .head_trig  (trig_q[0]),
         .right_slot (r_slot),
         .right_trig (r_trig),
         .left_slot  (l_slot),
         .left_trig  (l_trig),
         .slot_q     (slot_q[i]),
         .trig_q     (trig_q[i])
      );
   end

   assign head_slot = slot_q[0];
   assign head_trig = trig_q[0];

endmodule

`default_nettype wire

/* rtl/timer_event_list_scheduler_core.sv */
// Flow: a request is done after its walk through the n armed slots (n at most SLOTS)
//   and the finish state; a tick also waits whenever the response side stalls.
// Requests: a new one is taken only in idle, after the last is done; the list rotates
//   through the head cell one entry per cycle while no tick waits on a full response.
// Reset: synchronous, active high; list empty and time zero, no sweep.
// ----------------------------------------------------------------------------
// Timer list scheduler core
// Software-style timer list held in a row of cells, newest slot first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timer_event_list_scheduler_core_assert.svh"

module timer_event_list_scheduler_core
   import tel_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   tel_req_if.sink  req_chan,
   tel_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(SLOTS + 1);

   // The list lives in cells 0..count-1, front at cell 0. Each remove, tick and
   // in-pool add walks the list once: each unstalled cycle the head leaves cell 0,
   // all cells move one left, and it re-enters at the tail unless dropped. After
   // count steps the survivors are back in order and packed. Drop rule: slot match
   // for add/remove, trigger reached for tick. An add then pushes its slot in front.

   state_type             state_ff, state_in;
   logic [OP_BITS-1:0]    op_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [TIME_BITS-1:0]  trig_ff;
   logic [TIME_BITS-1:0]  cur_time_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CNT_BITS-1:0]   remain_ff;

   // one fired slot is held back so the last one can be marked
   logic                  pend_valid_ff;
   logic [SLOT_BITS-1:0]  pend_slot_ff;

   // response register
   logic                       rsp_valid_ff;
   logic                       rsp_fired_ff;
   logic [SLOT_BITS-1:0]       rsp_slot_ff;
   logic [TIME_FIELD_BITS-1:0] rsp_time_ff;
   logic                       rsp_last_ff;

   logic                  accept;
   logic                  out_free;
   logic                  is_tick, is_add;
   logic [SLOT_BITS-1:0]  head_slot;
   logic [TIME_BITS-1:0]  head_trig;
   logic                  head_expired, head_drop;
   logic                  stall, step;
   logic                  push_fire, push_final;
   chain_ctrl_type        chain_ctrl;

   logic [TIME_BITS-1:0]  delay_t;
   logic [TIME_BITS:0]    trig_sum;
   logic [TIME_BITS-1:0]  add_trig;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign is_tick = (op_ff == OP_TICK);
   assign is_add  = (op_ff == OP_ADD);

   // new trigger time from the last tick, clamped at the top of the range
   assign delay_t  = TIME_BITS'(req_chan.delay_ticks);
   assign trig_sum = {1'b0, cur_time_ff} + {1'b0, delay_t};
   assign add_trig = trig_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : trig_sum[TIME_BITS-1:0];

   assign head_expired = (cur_time_ff >= head_trig);
   assign head_drop    = is_tick ? head_expired : (head_slot == slot_ff);

   // a new fire pushes the held one out; wait if the response is still full
   assign stall = is_tick && head_expired && pend_valid_ff && !out_free;
   assign step  = (state_ff == ST_PASS) && (remain_ff != '0) && !stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.op)
                  OP_ADD: begin
                     // slot numbers outside the pool are ignored
                     if (int'(req_chan.slot_id) < SLOTS) state_in = ST_PASS;
                  end
                  OP_REMOVE: state_in = ST_PASS;
                  OP_TICK:   state_in = ST_PASS;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_PASS: begin
            if (remain_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!is_tick || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      chain_ctrl.shift_left  = step;
      chain_ctrl.keep_head   = step && !head_drop;
      chain_ctrl.shift_right = (state_ff == ST_FINISH) && is_add;
      push_fire  = step && is_tick && head_expired && pend_valid_ff;
      push_final = (state_ff == ST_FINISH) && is_tick && out_free;
   end

   tel_chain #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS)
   ) u_chain (
      .clock     (clock),
      .ctrl      (chain_ctrl),
      .count     (cnt_ff),
      .ins_slot  (slot_ff),
      .ins_trig  (trig_ff),
      .head_slot (head_slot),
      .head_trig (head_trig)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_time_ff   <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && (req_chan.op == OP_TICK)) begin
            cur_time_ff <= TIME_BITS'(req_chan.now_ticks);
         end
         if (step && head_drop) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
         end else if (chain_ctrl.shift_right) begin
            cnt_ff <= cnt_ff + CNT_BITS'(1);
         end
         if (step && is_tick && head_expired) begin
            pend_valid_ff <= 1'b1;
         end else if (push_final) begin
            pend_valid_ff <= 1'b0;
         end
         if (push_fire || push_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_chan.op;
         slot_ff   <= req_chan.slot_id;
         trig_ff   <= add_trig;
         remain_ff <= cnt_ff;
      end else if (step) begin
         remain_ff <= remain_ff - CNT_BITS'(1);
      end
      if (step && is_tick && head_expired) begin
         pend_slot_ff <= head_slot;
      end
      if (push_fire) begin
         rsp_fired_ff <= 1'b1;
         rsp_slot_ff  <= pend_slot_ff;
         rsp_time_ff  <= TIME_FIELD_BITS'(cur_time_ff);
         rsp_last_ff  <= 1'b0;
      end else if (push_final) begin
         // last result: the held fire, or an empty marker if nothing fired
         rsp_fired_ff <= pend_valid_ff;
         rsp_slot_ff  <= pend_valid_ff ? pend_slot_ff : '0;
         rsp_time_ff  <= TIME_FIELD_BITS'(cur_time_ff);
         rsp_last_ff  <= 1'b1;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.fired       = rsp_fired_ff;
   assign rsp_chan.fired_slot  = rsp_slot_ff;
   assign rsp_chan.fire_time   = rsp_time_ff;
   assign rsp_chan.last_result = rsp_last_ff;

   // unexamined entries are always part of the occupied list
   `TEL_ASSERT_IMPL(a_remain_in_list, clock, reset, state_ff == ST_PASS, remain_ff <= cnt_ff, "walk count exceeds list length")
   // an add always finds room at the front once its old entry is gone
   `TEL_ASSERT_IMPL(a_add_room, clock, reset, chain_ctrl.shift_right, int'(cnt_ff) < SLOTS, "insert into a full chain")
   // a held fire only exists while a tick is in progress
   `TEL_ASSERT_IMPL(a_pend_in_tick, clock, reset, pend_valid_ff, (state_ff != ST_IDLE) && is_tick, "held fire outside a tick")
   // an accepted tick always starts a walk
   `TEL_ASSERT_NEXT(a_tick_walks, clock, reset, accept && (req_chan.op == OP_TICK), state_ff == ST_PASS, "tick did not start a walk")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer list scheduler testbench
// Drives add, remove and tick requests into the scheduler core, keeps a
// shadow copy of the slot list and checks every expiry report it returns.
// ----------------------------------------------------------------------------

module tb;
   import tel_pkg::*;

   localparam int          N_SLOTS    = SLOTS_DEF;
   localparam logic [4:0]  NO_LINK    = 5'(SLOTS_DEF);
   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   localparam int          IDLE_PCT   = 27;
   localparam int          HOLD_LEN   = 300;     // long response-side stall
   localparam int          SETTLE     = 40;      // outlasts one request walk of the core
   localparam int unsigned LIMIT      = 400000;

   // one expiry report as seen on the response channel
   typedef struct packed {
      logic                       fired;
      logic [SLOT_BITS-1:0]       slot;
      logic [TIME_FIELD_BITS-1:0] fire_at;
      logic                       last;
   } fire_rec_type;

   // -------------------------------------------------------------------------
   // Shadow of the timer list plus the queue of expiry reports still owed.
   // -------------------------------------------------------------------------
   class expiry_board;
      logic [31:0]  clock_now;
      logic [31:0]  due_at  [N_SLOTS];
      bit           live    [N_SLOTS];
      logic [4:0]   next_of [N_SLOTS];
      logic [4:0]   prev_of [N_SLOTS];
      logic [4:0]   head;
      fire_rec_type due_fires [$];
      int           errors;

      function new();
         clock_now = '0;
         head      = NO_LINK;
         errors    = 0;
         foreach (live[i]) begin
            live[i]    = 1'b0;
            due_at[i]  = '0;
            next_of[i] = NO_LINK;
            prev_of[i] = NO_LINK;
         end
      endfunction

      function void drop(int s);
         logic [4:0] p;
         logic [4:0] n;
         p = prev_of[s];
         n = next_of[s];
         if (p >= NO_LINK) begin
            head = n;
         end else begin
            next_of[p] = n;
         end
         if (n < NO_LINK) begin
            prev_of[n] = p;
         end
         live[s] = 1'b0;
      endfunction

      function void push_front(int s);
         next_of[s] = head;
         prev_of[s] = NO_LINK;
         if (head < NO_LINK) begin
            prev_of[head] = 5'(s);
         end
         head    = 5'(s);
         live[s] = 1'b1;
      endfunction

      // called once per accepted request
      function void take_request(logic [1:0] op, logic [3:0] slot, logic [31:0] delay,
                                 logic [31:0] now);
         logic [32:0]  sum;
         int           cur;
         int           steps;
         int           n_fired;
         fire_rec_type rec;
         case (op)
            OP_ADD: begin
               // re-add of a live slot moves it to the front
               if (live[slot]) drop(slot);
               sum          = {1'b0, clock_now} + {1'b0, delay};
               due_at[slot] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               push_front(slot);
            end
            OP_REMOVE: begin
               if (live[slot]) drop(slot);
            end
            OP_TICK: begin
               clock_now = now;
               cur       = head;
               steps     = 0;
               n_fired   = 0;
               while (cur < N_SLOTS && steps < N_SLOTS) begin
                  rec.slot = 4'(cur);
                  cur      = next_of[cur];
                  if (clock_now >= due_at[rec.slot]) begin
                     drop(rec.slot);
                     rec.fired   = 1'b1;
                     rec.fire_at = clock_now;
                     rec.last    = 1'b0;
                     due_fires.push_back(rec);
                     n_fired++;
                  end
                  steps++;
               end
               if (n_fired == 0) begin
                  rec.fired   = 1'b0;
                  rec.slot    = '0;
                  rec.fire_at = clock_now;
                  rec.last    = 1'b1;
                  due_fires.push_back(rec);
               end else begin
                  due_fires[due_fires.size() - 1].last = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
         errors++;
         $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
      endfunction

      // called once per accepted response
      function void match_fire(fire_rec_type got);
         fire_rec_type want;
         if (due_fires.size() == 0) begin
            report("unexpected transfer, fire_time", 32'h0, got.fire_at);
            return;
         end
         want = due_fires.pop_front();
         if (got.fired   !== want.fired)   report("fired", want.fired, got.fired);
         if (got.slot    !== want.slot)    report("fired_slot", want.slot, got.slot);
         if (got.fire_at !== want.fire_at) report("fire_time", want.fire_at, got.fire_at);
         if (got.last    !== want.last)    report("last_result", want.last, got.last);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the core
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   tel_req_if req_bus ();
   tel_rsp_if rsp_bus ();

   timer_event_list_scheduler_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   expiry_board fire_book;

   bit          steady    = 1'b0;   // no idling on either side while set
   int          hold_asks = 0;      // bumped by the stimulus to request a stall
   int          hold_seen = 0;
   int          hold_left = 0;
   int unsigned cycles    = 0;

   // all inputs known from time zero
   initial begin
      fire_book           = new();
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_ADD;
      req_bus.slot_id     = '0;
      req_bus.delay_ticks = '0;
      req_bus.now_ticks   = '0;
      rsp_bus.ready       = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Response side: random back-pressure, plus long holds on request.
   // The hold is counted here so the sender can keep pushing meanwhile.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // every response transfer is checked against the oldest report owed
   always @(posedge clock) begin
      fire_rec_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.fired   = rsp_bus.fired;
         got.slot    = rsp_bus.fired_slot;
         got.fire_at = rsp_bus.fire_time;
         got.last    = rsp_bus.last_result;
         fire_book.match_fire(got);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request, with a random gap in front of it unless steady.
   // Valid stays high on return so back-to-back transfers need no re-raise.
   task automatic send_item(input logic [1:0] op, input logic [3:0] slot,
                            input logic [31:0] delay, input logic [31:0] now);
      int gap;
      gap = 0;
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.slot_id     <= slot;
      req_bus.delay_ticks <= delay;
      req_bus.now_ticks   <= now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      fire_book.take_request(op, slot, delay, now);
   endtask

   // sender goes quiet until every owed report has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (fire_book.due_fires.size() != 0);
   endtask

   initial begin
      logic [31:0] tb_now;
      logic [31:0] delay;
      logic [31:0] now;
      int          n_items;
      int          pick;
      int          next_pause;
      bit          second_hold;

      tb_now      = '0;
      n_items     = 0;
      next_pause  = 70;
      second_hold = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // ---- directed corners ----
      // empty list: a tick still reports, with fired low
      send_item(OP_TICK,   4'd0,  32'd0,  32'd0);
      // zero delay expires on the very next tick at the same time
      send_item(OP_ADD,    4'd0,  32'd0,  32'hFFFF_FFFF);
      send_item(OP_TICK,   4'd0,  32'hFFFF_FFFF, 32'd0);
      // re-adding a live slot re-times it and moves it to the front
      send_item(OP_ADD,    4'd5,  32'd10, 32'd0);
      send_item(OP_ADD,    4'd9,  32'd20, 32'd0);
      send_item(OP_ADD,    4'd5,  32'd30, 32'd0);
      // remove of an idle slot and the unused opcode do nothing
      send_item(OP_REMOVE, 4'd12, 32'd0,  32'd0);
      send_item(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_TICK,   4'd0,  32'd0,  32'd10);
      send_item(OP_TICK,   4'd0,  32'd0,  32'd25);
      send_item(OP_REMOVE, 4'd5,  32'd0,  32'd0);
      send_item(OP_TICK,   4'd0,  32'd0,  32'd1000);
      // trigger time right at the top, one past it, and far past it
      send_item(OP_ADD,    4'd15, 32'hFFFF_FFFF, 32'd0);
      send_item(OP_ADD,    4'd10, 32'hFFFF_FFFF - 32'd1000, 32'd0);
      send_item(OP_ADD,    4'd11, 32'hFFFF_FFFF - 32'd999,  32'd0);
      send_item(OP_TICK,   4'd0,  32'd0,  32'hFFFF_FFFE);
      send_item(OP_TICK,   4'd0,  32'd0,  32'hFFFF_FFFF);
      // time may also go backwards
      send_item(OP_TICK,   4'd0,  32'd0,  32'd0);
      wait_drained();

      // ---- full list under a long response stall ----
      for (int i = 0; i < N_SLOTS; i++) begin
         send_item(OP_ADD, 4'(i), $urandom_range(0, 40), $urandom);
      end
      hold_asks = hold_asks + 1;
      for (int i = 0; i < 6; i++) begin
         tb_now = tb_now + $urandom_range(5, 15);
         send_item(OP_TICK, 4'($urandom), $urandom, tb_now);
      end
      wait_drained();

      // ---- random traffic ----
      // Mostly slowly advancing time with short delays so slots really
      // expire; a few wide-open values as noise.
      while (n_items < 200) begin
         steady = (n_items >= 90 && n_items < 150);
         if (n_items >= next_pause) begin
            next_pause = next_pause + 70;
            wait_drained();
         end
         if (!second_hold && n_items >= 170) begin
            second_hold = 1'b1;
            hold_asks   = hold_asks + 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 36) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)      delay = $urandom_range(0, 300);
            else if (pick < 95) delay = $urandom;
            else                delay = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_item(OP_ADD, 4'($urandom), delay, $urandom);
            n_items++;
         end else if (pick < 50) begin
            send_item(OP_REMOVE, 4'($urandom), $urandom, $urandom);
            n_items++;
         end else if (pick < 94) begin
            if ($urandom_range(0, 99) < 8) now = $urandom;
            else                           now = tb_now + $urandom_range(0, 120);
            tb_now = now;
            send_item(OP_TICK, 4'($urandom), $urandom, now);
            n_items++;
         end else begin
            send_item(OP_UNUSED, 4'($urandom), $urandom, $urandom);
         end
      end
      steady = 1'b0;

      // ---- wind down ----
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (fire_book.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
